### design/tpt_pkg.sv
// Shared types, register indexes and reset constants for the pixel temperature core.
package tpt_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BIAS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_SHIFT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EMISSION_SUB = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_EMIS_DIV = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_BIAS     = 3'd7;

  localparam logic signed [16:0] RST_PIXEL_OFFSET = 17'sd0;
  localparam logic signed [31:0] RST_PIXEL_SCALE  = 32'sd65536;
  localparam logic signed [31:0] RST_PIXEL_BIAS   = 32'sd0;
  localparam logic signed [31:0] RST_ROOT_SHIFT   = 32'sd17901158;
  localparam logic [62:0]        RST_EMISSION_SUB = 63'd0;
  localparam logic [31:0]        RST_INV_EMIS_DIV = 32'd65536;
  localparam logic signed [31:0] RST_OUT_GAIN     = 32'sd65536;
  localparam logic signed [31:0] RST_OUT_BIAS     = -32'sd17901158;

  typedef struct packed {
    logic signed [16:0] pixel_offset;
    logic signed [31:0] pixel_scale;
    logic signed [31:0] pixel_bias;
    logic signed [31:0] root_shift;
    logic [62:0]        emission_sub;
    logic [31:0]        inv_emission_div;
    logic signed [31:0] out_gain;
    logic signed [31:0] out_bias;
  } cfg_t;

endpackage

### design/tpt_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage, with sideband.
module tpt_sqrt_pipe #(
  parameter int RW = 32,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] in_rad,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [RW-1:0]   out_root,
  output logic [SW-1:0]   out_side
);
  // Classic restoring digit-by-digit square root; each stage handles one bit.
  logic [2*RW-1:0] rem  [0:RW];
  logic [2*RW-1:0] rad  [0:RW];
  logic [RW-1:0]   root [0:RW];
  logic [SW-1:0]   side [0:RW];
  logic            vld  [0:RW];

  assign rem[0]  = '0;
  assign rad[0]  = in_rad;
  assign root[0] = '0;
  assign side[0] = in_side;
  assign vld[0]  = in_valid;

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [2*RW+1:0] rem_sh;
    logic [2*RW+1:0] trial;
    logic            fits;
    assign rem_sh = {rem[i], rad[i][2*RW-1 -: 2]};
    // (2q+1)^2 - (2q)^2 = 4q+1
    assign trial  = {{RW{1'b0}}, root[i], 2'b01};
    assign fits   = rem_sh >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= fits ? (2*RW)'(rem_sh - trial) : (2*RW)'(rem_sh);
        rad[i+1]  <= {rad[i][2*RW-3:0], 2'b00};
        root[i+1] <= {root[i][RW-2:0], fits};
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = vld[RW];
  assign out_root  = root[RW];
  assign out_side  = side[RW];
endmodule

### design/tpt_mul_pipe.sv
// Pipelined unsigned multiplier built from 32x32 partial products, sideband carried.
module tpt_mul_pipe #(
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [63:0]   in_a,
  input  logic [63:0]   in_b,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [127:0]  out_prod,
  output logic [SW-1:0] out_side
);
  logic [63:0]   ll, lh, hl, hh;
  logic [SW-1:0] side1, side2;
  logic          vld1, vld2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else if (en) begin
      vld1 <= in_valid;
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll       <= in_a[31:0]  * in_b[31:0];
      lh       <= in_a[31:0]  * in_b[63:32];
      hl       <= in_a[63:32] * in_b[31:0];
      hh       <= in_a[63:32] * in_b[63:32];
      side1    <= in_side;
      out_prod <= {hh, ll} + {32'd0, lh, 32'd0} + {32'd0, hl, 32'd0};
      side2    <= side1;
    end
  end

  assign out_valid = vld2;
  assign out_side  = side2;
endmodule

### design/thermal_pixel_to_temperature_core.sv
// Top level of the radiometric pixel to temperature converter.
// One raw pixel enters per clock and one Q16.16 Celsius temperature leaves per
// clock when the result side does not stall; the pipeline holds the three
// bit-per-stage square roots (34 + 52 + 26 stages) and the multiplier and
// arithmetic stages around them. The whole pipeline advances only when the
// output register is empty or being taken, so a stall on the result side holds
// every stage in place. A negative square-root operand, or a fourth power below
// the radiance term, gives invalid = 1 and temperature = 0. Configuration is
// written through its own valid/ready port, always ready; every index is used.
module thermal_pixel_to_temperature_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         raw_pixel,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  temperature,
  output logic                invalid
);
  import tpt_pkg::*;

  cfg_t cfg;

  // ---- configuration registers ----
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_offset     <= RST_PIXEL_OFFSET;
      cfg.pixel_scale      <= RST_PIXEL_SCALE;
      cfg.pixel_bias       <= RST_PIXEL_BIAS;
      cfg.root_shift       <= RST_ROOT_SHIFT;
      cfg.emission_sub     <= RST_EMISSION_SUB;
      cfg.inv_emission_div <= RST_INV_EMIS_DIV;
      cfg.out_gain         <= RST_OUT_GAIN;
      cfg.out_bias         <= RST_OUT_BIAS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PIXEL_OFFSET: cfg.pixel_offset     <= cfg_data[16:0];
        REG_PIXEL_SCALE:  cfg.pixel_scale      <= cfg_data[31:0];
        REG_PIXEL_BIAS:   cfg.pixel_bias       <= cfg_data[31:0];
        REG_ROOT_SHIFT:   cfg.root_shift       <= cfg_data[31:0];
        REG_EMISSION_SUB: cfg.emission_sub     <= cfg_data[62:0];
        REG_INV_EMIS_DIV: cfg.inv_emission_div <= cfg_data[31:0];
        REG_OUT_GAIN:     cfg.out_gain         <= cfg_data[31:0];
        REG_OUT_BIAS:     cfg.out_bias         <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Global advance: pipeline moves when the output slot is free or drains.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---- stage A: D = raw - offset, D * scale ----
  logic               a_vld;
  logic signed [17:0] a_d;
  logic signed [49:0] a_prod;
  logic               b_vld;
  logic signed [63:0] b_r;
  assign a_d = $signed({2'b00, raw_pixel}) - 18'(cfg.pixel_offset);
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
      b_vld <= a_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_prod <= a_d * cfg.pixel_scale;
      b_r    <= 64'(a_prod) + 64'(cfg.pixel_bias);
    end
  end

  // ---- sqrt of R * 2^16 ----
  // R < 2^49, so R * 2^16 < 2^65 and the root fits in 33 bits; 34-bit root.
  logic        s_vld;
  logic [33:0] s_root;
  logic [0:0]  s_neg;
  tpt_sqrt_pipe #(.RW(34), .SW(1)) u_sqrt1 (
    .clk, .rst, .en,
    .in_valid (b_vld),
    .in_rad   ({2'b00, (b_r[63] ? 50'd0 : b_r[49:0]), 16'd0}),
    .in_side  (b_r[63]),
    .out_valid(s_vld),
    .out_root (s_root),
    .out_side (s_neg)
  );

  // ---- T = S + shift, |T| ----
  logic        t_vld, t_neg, t_big;
  logic [31:0] t_abs;
  logic signed [35:0] t_sum;
  assign t_sum = $signed({2'b00, s_root}) + 36'(cfg.root_shift);
  always_ff @(posedge clk) begin
    if (rst) t_vld <= 1'b0;
    else if (en) t_vld <= s_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      logic [35:0] mag;
      mag   = t_sum[35] ? 36'(-t_sum) : 36'(t_sum);
      t_neg <= s_neg[0];
      t_big <= |mag[35:32];
      t_abs <= mag[31:0];
    end
  end

  // ---- q = a*a (32x32) ----
  logic        q_vld, q_neg, q_big;
  logic [63:0] q;
  always_ff @(posedge clk) begin
    if (rst) q_vld <= 1'b0;
    else if (en) q_vld <= t_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      q     <= t_abs * t_abs;
      q_neg <= t_neg;
      q_big <= t_big;
    end
  end

  // ---- q*q ----
  logic         p_vld;
  logic [127:0] p4;
  logic [1:0]   p_side;
  tpt_mul_pipe #(.SW(2)) u_mul4 (
    .clk, .rst, .en,
    .in_valid (q_vld), .in_a(q), .in_b(q), .in_side({q_neg, q_big}),
    .out_valid(p_vld), .out_prod(p4), .out_side(p_side)
  );

  // ---- W, N = W - sub ----
  logic        n_vld, n_inv;
  logic [62:0] n;
  always_ff @(posedge clk) begin
    if (rst) n_vld <= 1'b0;
    else if (en) n_vld <= p_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      logic [62:0] w;
      w     = (p_side[0] || (|p4[127:103])) ? {63{1'b1}} : p4[102:40];
      n_inv <= p_side[1] || (w < cfg.emission_sub);
      n     <= w - cfg.emission_sub;
    end
  end

  // ---- N * inv_div ----
  logic         m_vld;
  logic [127:0] mp;
  logic [0:0]   m_side;
  tpt_mul_pipe #(.SW(1)) u_muldiv (
    .clk, .rst, .en,
    .in_valid (n_vld), .in_a({1'b0, n}), .in_b({32'd0, cfg.inv_emission_div}),
    .in_side  (n_inv),
    .out_valid(m_vld), .out_prod(mp), .out_side(m_side)
  );

  logic        mm_vld, mm_inv;
  logic [63:0] mm;
  always_ff @(posedge clk) begin
    if (rst) mm_vld <= 1'b0;
    else if (en) mm_vld <= m_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mm     <= (|mp[127:80]) ? {64{1'b1}} : mp[79:16];
      mm_inv <= m_side[0];
    end
  end

  // ---- s1 = sqrt(M * 2^40), 104-bit operand, 52-bit root ----
  logic        s1_vld;
  logic [51:0] s1;
  logic [0:0]  s1_inv;
  tpt_sqrt_pipe #(.RW(52), .SW(1)) u_sqrt2 (
    .clk, .rst, .en,
    .in_valid (mm_vld), .in_rad({mm, 40'd0}), .in_side(mm_inv),
    .out_valid(s1_vld), .out_root(s1), .out_side(s1_inv)
  );

  // ---- k = sqrt(s1), 26-bit root ----
  logic        k_vld;
  logic [25:0] k;
  logic [0:0]  k_inv;
  tpt_sqrt_pipe #(.RW(26), .SW(1)) u_sqrt3 (
    .clk, .rst, .en,
    .in_valid (s1_vld), .in_rad(s1), .in_side(s1_inv),
    .out_valid(k_vld), .out_root(k), .out_side(k_inv)
  );

  // ---- Y = floor(k*gain/2^16) + bias, saturated ----
  logic               g_vld, g_inv;
  logic signed [58:0] g_prod;
  always_ff @(posedge clk) begin
    if (rst) g_vld <= 1'b0;
    else if (en) g_vld <= k_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      g_prod <= $signed({1'b0, k}) * cfg.out_gain;
      g_inv  <= k_inv[0];
    end
  end

  logic signed [43:0] y;
  assign y = 44'(g_prod >>> 16) + 44'(cfg.out_bias);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= g_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      invalid <= g_inv;
      if (g_inv) temperature <= '0;
      else if (y > 44'sd2147483647) temperature <= 32'sh7FFFFFFF;
      else if (y < -44'sd2147483648) temperature <= 32'sh80000000;
      else temperature <= y[31:0];
    end
  end

  // ---- checks ----
  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid |-> temperature == 32'sd0)
    else $error("invalid result with nonzero temperature");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(temperature))
    else $error("stalled result changed");
  a_stall_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during output stall");
endmodule

### sim/tpt_checker.sv
// Pixel temperature checker: tracks the register file, predicts each result and compares.
module tpt_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [15:0]        raw_pixel,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] temperature,
  input  logic               invalid,
  output int unsigned        fail_count,
  output int                 pending
);
  import tpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] temp;
    logic               inv;
  } temp_res_t;

  cfg_t      regs;
  temp_res_t temp_q[$];

  assign pending = temp_q.size();

  // floor square root of a 128-bit operand
  function automatic logic [63:0] root128(input logic [127:0] x);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= x) r = c;
    end
    return r;
  endfunction

  function automatic temp_res_t convert_pixel(input cfg_t c, input logic [15:0] px);
    logic signed [63:0] off, scl, bia, rsh, gain, obias;
    logic signed [63:0] d, r, t, p, y;
    logic [63:0]        a, q, w, n, m, s, s1, k;
    logic [127:0]       pr;
    temp_res_t          res;
    off = c.pixel_offset;
    scl = c.pixel_scale;
    bia = c.pixel_bias;
    rsh = c.root_shift;
    gain = c.out_gain;
    obias = c.out_bias;
    res = '{temp: '0, inv: 1'b1};
    d = $signed({48'd0, px}) - off;
    r = d * scl + bia;
    if (r < 0) return res;
    s = root128({64'd0, r} << 16);
    t = $signed(s) + rsh;
    a = (t < 0) ? -t : t;
    // fourth power in Q39.24, saturated to 63 bits
    if (a >= 64'h1_0000_0000) begin
      w = 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      q  = a * a;
      pr = {64'd0, q} * {64'd0, q};
      if (pr[127:64] >= (64'd1 << 39)) w = 64'h7FFF_FFFF_FFFF_FFFF;
      else w = pr[103:40];
    end
    if (w < {1'b0, c.emission_sub}) return res;
    n  = w - {1'b0, c.emission_sub};
    pr = {64'd0, n} * {96'd0, c.inv_emission_div};
    if (pr[127:80] != 0) m = '1;
    else m = pr[79:16];
    s1 = root128({24'd0, m, 40'd0});
    k  = root128({64'd0, s1});
    p  = $signed(k) * gain;
    p  = p >>> 16;
    y  = p + obias;
    if (y > 64'sd2147483647) y = 64'sd2147483647;
    if (y < -64'sd2147483648) y = -64'sd2147483648;
    res.temp = y[31:0];
    res.inv  = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin
    temp_res_t   want;
    int unsigned errs;
    errs = 0;
    if (rst) begin
      regs <= '{RST_PIXEL_OFFSET, RST_PIXEL_SCALE, RST_PIXEL_BIAS, RST_ROOT_SHIFT,
                RST_EMISSION_SUB, RST_INV_EMIS_DIV, RST_OUT_GAIN, RST_OUT_BIAS};
      temp_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PIXEL_OFFSET: regs.pixel_offset     <= cfg_data[16:0];
          REG_PIXEL_SCALE:  regs.pixel_scale      <= cfg_data[31:0];
          REG_PIXEL_BIAS:   regs.pixel_bias       <= cfg_data[31:0];
          REG_ROOT_SHIFT:   regs.root_shift       <= cfg_data[31:0];
          REG_EMISSION_SUB: regs.emission_sub     <= cfg_data[62:0];
          REG_INV_EMIS_DIV: regs.inv_emission_div <= cfg_data[31:0];
          REG_OUT_GAIN:     regs.out_gain         <= cfg_data[31:0];
          REG_OUT_BIAS:     regs.out_bias         <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) temp_q.push_back(convert_pixel(regs, raw_pixel));
      if (out_valid && out_ready) begin
        if (temp_q.size() == 0) begin
          $error("result transfer with nothing expected");
          errs++;
        end else begin
          want = temp_q.pop_front();
          if (temperature !== want.temp) begin
            $error("temperature: expected %0d, got %0d", want.temp, temperature);
            errs++;
          end
          if (invalid !== want.inv) begin
            $error("invalid: expected %0d, got %0d", want.inv, invalid);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

### sim/thermal_pixel_to_temperature_core_test.sv
// Testbench top for the pixel temperature core: stimulus, stalls and verdict.
module thermal_pixel_to_temperature_core_test;
  import tpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [15:0]        raw_pixel = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] temperature;
  logic               invalid;
  int unsigned        fail_count;
  int                 pending;

  // when set, neither side inserts gaps (back-to-back stretches)
  bit                 no_gaps = 1'b0;
  int unsigned        idle_cycles = 0;

  // watchdog covers a full pipe plus worst stalls many times over
  localparam int WATCHDOG_LIMIT = 5000;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  thermal_pixel_to_temperature_core u_top (.*);

  tpt_checker u_chk (.*);

  // Watchdog: any transfer on any channel resets the idle count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: a random stall before about half of the transfers, none when no_gaps is set.
  initial begin
    @(negedge rst);
    forever begin
      if (!no_gaps && $urandom_range(0, 1)) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Write all eight registers back to back; valid drops only after the last transfer.
  task automatic load_regs(input cfg_t c);
    logic [63:0] vals[8];
    vals[REG_PIXEL_OFFSET] = {{47{$urandom_range(0, 1) == 1}}, c.pixel_offset};
    vals[REG_PIXEL_SCALE]  = {$urandom, c.pixel_scale};
    vals[REG_PIXEL_BIAS]   = {$urandom, c.pixel_bias};
    vals[REG_ROOT_SHIFT]   = {$urandom, c.root_shift};
    vals[REG_EMISSION_SUB] = {$urandom_range(0, 1) == 1, c.emission_sub};
    vals[REG_INV_EMIS_DIV] = {$urandom, c.inv_emission_div};
    vals[REG_OUT_GAIN]     = {$urandom, c.out_gain};
    vals[REG_OUT_BIAS]     = {$urandom, c.out_bias};
    // stop the input, let the last transfer reach the checker, then drain
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(input logic [15:0] px);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    raw_pixel <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic cfg_t default_regs();
    return '{RST_PIXEL_OFFSET, RST_PIXEL_SCALE, RST_PIXEL_BIAS, RST_ROOT_SHIFT,
             RST_EMISSION_SUB, RST_INV_EMIS_DIV, RST_OUT_GAIN, RST_OUT_BIAS};
  endfunction

  // Plausible camera settings: most pixels land on a valid temperature.
  function automatic cfg_t plausible_regs();
    cfg_t c;
    c.pixel_offset     = 17'($urandom_range(0, 4095));
    c.pixel_scale      = $urandom_range(4096, 262144);
    c.pixel_bias       = $signed($urandom_range(0, 2 ** 20)) - 32'sd65536;
    c.root_shift       = RST_ROOT_SHIFT + $signed($urandom_range(0, 2 ** 23)) - 32'sd4194304;
    c.emission_sub     = {7'd0, $urandom, 24'($urandom_range(0, 2 ** 24 - 1))};
    c.inv_emission_div = $urandom_range(32768, 131072);
    c.out_gain         = $urandom_range(58000, 73000);
    c.out_bias         = RST_OUT_BIAS + $signed($urandom_range(0, 2 ** 22)) - 32'sd2097152;
    return c;
  endfunction

  // Any register value, with the field extremes drawn often.
  function automatic logic [63:0] wild(input int w, input bit sgn);
    logic [63:0] v;
    case ($urandom_range(0, 3))
      0: v = sgn ? (64'd1 << (w - 1)) : 64'd0;
      1: v = sgn ? ((64'd1 << (w - 1)) - 1) : ((64'd1 << w) - 1);
      default: v = {$urandom, $urandom} & ((64'd1 << w) - 1);
    endcase
    return v;
  endfunction

  function automatic cfg_t wild_regs();
    cfg_t c;
    c = plausible_regs();
    // replace a random subset so some conversions still reach the end
    if ($urandom_range(0, 1)) c.pixel_offset = 17'(wild(17, 1));
    if ($urandom_range(0, 1)) c.pixel_scale = 32'(wild(32, 1));
    if ($urandom_range(0, 1)) c.pixel_bias = 32'(wild(32, 1));
    if ($urandom_range(0, 1)) c.root_shift = 32'(wild(32, 1));
    if ($urandom_range(0, 1)) c.emission_sub = 63'(wild(63, 0));
    if ($urandom_range(0, 1)) c.inv_emission_div = 32'(wild(32, 0));
    if ($urandom_range(0, 1)) c.out_gain = 32'(wild(32, 1));
    if ($urandom_range(0, 1)) c.out_bias = 32'(wild(32, 1));
    return c;
  endfunction

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    cfg_t c;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, field extremes and alternating bit patterns.
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'h0001);
    send_pixel(16'h8000);
    send_pixel(16'h5555);
    send_pixel(16'hAAAA);

    // Negative square-root operand: negative pixel scale on a positive difference.
    c = default_regs();
    c.pixel_scale = 32'sh8000_0000;
    load_regs(c);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);

    // Radiance term above any fourth power: negative fourth-root operand.
    c = default_regs();
    c.emission_sub = '1;
    load_regs(c);
    send_pixel(16'h1234);
    send_pixel(16'hFFFF);

    // Kelvin value far below zero, raised as its magnitude.
    c = default_regs();
    c.root_shift = 32'sh8000_0000;
    load_regs(c);
    send_pixel(16'h0000);
    send_pixel(16'h00FF);

    // Power and scaled overflow, output saturating high.
    c = '{17'sh10000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          63'd0, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    load_regs(c);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);

    // Output at the most negative value: zero inverse divisor, most negative gain and bias.
    c.out_gain = 32'sh8000_0000;
    c.out_bias = 32'sh8000_0000;
    c.inv_emission_div = 32'd0;
    load_regs(c);
    send_pixel(16'hFFFF);
    send_pixel(16'h7FFF);

    // Largest positive offset, zero scale: radicand is just the bias.
    c = '{17'sh0FFFF, 32'sd0, 32'sd0, 32'sd0, 63'd0, 32'd0, 32'sd0, 32'sd0};
    load_regs(c);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);

    // Random phases: mostly plausible settings, some wild ones, a few calm.
    for (int ph = 0; ph < 18; ph++) begin
      load_regs((ph % 3 == 2) ? wild_regs() : plausible_regs());
      no_gaps = (ph % 5 == 1);
      for (int i = 0; i < 105; i++) send_pixel(rand_pixel());
      in_valid <= 1'b0;
    end
    no_gaps = 1'b0;

    // Finish with the reset settings restored.
    load_regs(default_regs());
    for (int i = 0; i < 10; i++) send_pixel(rand_pixel());
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
